// ----- rtl/hls_pkg.sv -----
package hls_pkg;

  // request kinds carried in s_tuser
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_TARGET_TEMP = 3'd0,
    REG_SPEED_LOW   = 3'd1,
    REG_SPEED_MID   = 3'd2,
    REG_SPEED_HIGH  = 3'd3,
    REG_SPEED_MAX   = 3'd4
  } reg_idx_t;

  // phase codes as reported on the output
  localparam logic [2:0] PH_STANDBY  = 3'd0;
  localparam logic [2:0] PH_FUEL     = 3'd1;
  localparam logic [2:0] PH_IGNITION = 3'd2;
  localparam logic [2:0] PH_WARMUP   = 3'd3;
  localparam logic [2:0] PH_COOLING  = 3'd4;
  localparam logic [2:0] PH_SILENT   = 3'd5;
  localparam logic [2:0] PH_THERMO   = 3'd6;

  // one-hot sequencer state
  typedef enum logic [6:0] {
    S_STANDBY  = 7'b0000001,
    S_FUEL     = 7'b0000010,
    S_IGNITION = 7'b0000100,
    S_WARMUP   = 7'b0001000,
    S_COOLING  = 7'b0010000,
    S_SILENT   = 7'b0100000,
    S_THERMO   = 7'b1000000
  } phase_t;

  // flame threshold and timeouts in milliseconds
  localparam logic signed [10:0] FLAME_HOT = 11'sd45;
  localparam int T_SPINUP = 3000;
  localparam int T_GLOW   = 5000;
  localparam int T_LIGHT  = 30000;
  localparam int T_WARM   = 40000;
  localparam int T_NOREAD = 60000;
  localparam int T_PUMPUP = 90000;

  // reset values of the configuration registers
  localparam logic signed [7:0] TARGET_TEMP_RST = 8'sd20;
  localparam logic [7:0] SPEED_LOW_RST  = 8'd20;
  localparam logic [7:0] SPEED_MID_RST  = 8'd40;
  localparam logic [7:0] SPEED_HIGH_RST = 8'd60;
  localparam logic [7:0] SPEED_MAX_RST  = 8'd100;

  // result item, phase in the lowest bits
  typedef struct packed {
    logic [7:0] rate_value;
    logic       rate_write;
    logic [7:0] speed_value;
    logic       speed_write;
    logic       pump_start;
    logic       ignite_off;
    logic       ignite_on;
    logic       auto_enable;
    logic       engine_start;
    logic       halted;
    logic [2:0] phase;
  } result_t;

  function automatic logic [2:0] phase_code(phase_t p);
    logic [2:0] c;
    unique case (p)
      S_STANDBY:  c = PH_STANDBY;
      S_FUEL:     c = PH_FUEL;
      S_IGNITION: c = PH_IGNITION;
      S_WARMUP:   c = PH_WARMUP;
      S_COOLING:  c = PH_COOLING;
      S_SILENT:   c = PH_SILENT;
      S_THERMO:   c = PH_THERMO;
      default:    c = PH_SILENT;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/heater_launch_sequencer_top.sv -----
// a request passes through the input register and then the result register before it is offered
// throughput: one request per cycle while m_tready is high; s_tready follows m_tready
// combinationally, and drops only when the input and result registers both hold a request
// the phase, stop flag and timer update in the one compute stage per request
// rst (synchronous, active high) clears phase to standby, stop flag, timer,
// the pipeline valids, and loads the configuration reset values
module heater_launch_sequencer_top
  import hls_pkg::*;
#(
  parameter int TIMER_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [7:0]  cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // auto_mode[0], engine_speed_now[8:1], flame_temp[19:9],
                                // space_temp[27:20], zero fill
  input  logic [1:0]  s_tuser,  // op[1:0]
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // phase[2:0], halted[3], engine_start[4], auto_enable[5],
                                // ignite_on[6], ignite_off[7], pump_start[8], speed_write[9],
                                // speed_value[17:10], rate_write[18], rate_value[26:19]
);

  localparam logic [TIMER_BITS-1:0] TMAX      = '1;
  localparam logic [TIMER_BITS-1:0] LIM_SPIN  = TIMER_BITS'(T_SPINUP);
  localparam logic [TIMER_BITS-1:0] LIM_GLOW  = TIMER_BITS'(T_GLOW);
  localparam logic [TIMER_BITS-1:0] LIM_LIGHT = TIMER_BITS'(T_LIGHT);
  localparam logic [TIMER_BITS-1:0] LIM_WARM  = TIMER_BITS'(T_WARM);
  localparam logic [TIMER_BITS-1:0] LIM_NORD  = TIMER_BITS'(T_NOREAD);
  localparam logic [TIMER_BITS-1:0] LIM_PUMP  = TIMER_BITS'(T_PUMPUP);

  // configuration registers
  logic signed [7:0] target_temp;
  logic [7:0] speed_low, speed_mid, speed_high, speed_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_temp <= TARGET_TEMP_RST;
      speed_low   <= SPEED_LOW_RST;
      speed_mid   <= SPEED_MID_RST;
      speed_high  <= SPEED_HIGH_RST;
      speed_max   <= SPEED_MAX_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_TARGET_TEMP: target_temp <= cfg_data;
        REG_SPEED_LOW:   speed_low   <= cfg_data;
        REG_SPEED_MID:   speed_mid   <= cfg_data;
        REG_SPEED_HIGH:  speed_high  <= cfg_data;
        REG_SPEED_MAX:   speed_max   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register stage
  logic              in_valid;
  op_t               in_op;
  logic              in_auto;
  logic [7:0]        in_eng;
  logic signed [10:0] in_flame;
  logic signed [7:0] in_space;
  logic              advance;

  logic    out_valid;
  result_t out_res;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op    <= op_t'(s_tuser);
      in_auto  <= s_tdata[0];
      in_eng   <= s_tdata[8:1];
      in_flame <= s_tdata[19:9];
      in_space <= s_tdata[27:20];
    end
  end

  // sequencer state
  phase_t                phase_st, phase_next;
  logic                  stop_flag, stop_next;
  logic [TIMER_BITS-1:0] timer, timer_next, t_inc;
  result_t               res;
  logic                  space_warm, space_cold, run_ok;

  assign t_inc      = (timer == TMAX) ? timer : timer + 1'b1;
  assign space_warm = in_space >= target_temp;
  // hysteresis band: cold means space <= target - 2
  assign space_cold = 10'(signed'(in_space)) <= 10'(signed'(target_temp)) - 10'sd2;
  assign run_ok     = in_auto && !stop_flag;

  // next state and command pulses for the request in the input register
  always_comb begin
    phase_next = phase_st;
    stop_next  = stop_flag;
    timer_next = timer;
    res        = '0;
    case (in_op)
      OP_START: begin
        stop_next = 1'b0;
        if (phase_st == S_STANDBY) begin
          phase_next = S_COOLING;
          timer_next = '0;
        end
      end
      OP_STOP: begin
        stop_next  = 1'b1;
        phase_next = S_STANDBY;
        timer_next = '0;
      end
      OP_TICK: begin
        timer_next = t_inc;
        unique case (phase_st)
          S_STANDBY: begin
            if (run_ok) begin
              if ((in_flame == 11'sd0 && t_inc > LIM_NORD) ||
                  (in_flame != 11'sd0 && in_flame >= FLAME_HOT)) begin
                res.speed_write = 1'b1;
                res.speed_value = speed_max;
                if (space_warm) begin
                  phase_next = S_THERMO;
                  timer_next = '0;
                end
              end else if (in_flame != 11'sd0 && t_inc > LIM_PUMP) begin
                res.rate_write = 1'b1;
                res.rate_value = speed_high;
              end
            end
          end
          S_FUEL: begin
            if (t_inc > LIM_LIGHT) begin
              res.ignite_off = 1'b1;
              res.rate_write = 1'b1;
              res.rate_value = speed_low;
              phase_next     = S_WARMUP;
              timer_next     = '0;
            end
          end
          S_IGNITION: begin
            if (t_inc > LIM_GLOW) begin
              res.pump_start = 1'b1;
              res.rate_write = 1'b1;
              res.rate_value = speed_mid;
              phase_next     = S_FUEL;
              timer_next     = '0;
            end
          end
          S_WARMUP: begin
            if (t_inc > LIM_WARM) begin
              res.speed_write = 1'b1;
              res.speed_value = speed_max;
              res.rate_write  = 1'b1;
              res.rate_value  = speed_low;
              phase_next      = S_STANDBY;
              timer_next      = '0;
            end
          end
          S_COOLING: begin
            res.engine_start = 1'b1;
            res.auto_enable  = 1'b1;
            if (t_inc > LIM_SPIN) begin
              res.ignite_on = 1'b1;
              phase_next    = S_IGNITION;
              timer_next    = '0;
            end
          end
          S_THERMO: begin
            if (run_ok) begin
              if (space_warm) begin
                if (in_eng != speed_mid) begin
                  res.speed_write = 1'b1;
                  res.speed_value = speed_mid;
                end
              end else if (space_cold) begin
                if (in_eng != speed_high) begin
                  res.speed_write = 1'b1;
                  res.speed_value = speed_high;
                end
              end
            end
          end
          S_SILENT: ;
          default: ;
        endcase
      end
      default: ;
    endcase
    res.phase  = phase_code(phase_next);
    res.halted = stop_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_st  <= S_STANDBY;
      stop_flag <= 1'b0;
      timer     <= '0;
    end else if (advance) begin
      phase_st  <= phase_next;
      stop_flag <= stop_next;
      timer     <= timer_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_res};

  // a halted sequencer always sits in standby
  a_halt_standby: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_res.halted || out_res.phase == PH_STANDBY))
    else $error("halted result outside standby");

  // ignition pulse only on the move into ignition
  a_ignite_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.ignite_on |-> out_res.phase == PH_IGNITION)
    else $error("ignite_on without ignition phase");

  // every phase change restarts the timer
  a_timer_restart: assert property (@(posedge clk) disable iff (rst)
    (phase_st != $past(phase_st)) |-> timer == '0)
    else $error("timer not cleared on phase change");

  // unused value fields read as zero
  a_values_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_res.speed_write || out_res.speed_value == 8'd0) &&
                   (out_res.rate_write || out_res.rate_value == 8'd0)))
    else $error("value field set without its write flag");

endmodule

// ----- dv/heater_launch_sequencer_top_tb.sv -----
module heater_launch_sequencer_top_tb;
  import hls_pkg::*;

  localparam int TIMER_W = 32;
  localparam int CYCLE_LIMIT = 100_000;

  // one request on the input stream
  typedef struct {
    op_t               op;
    logic              auto_mode;
    logic [7:0]        eng;
    logic signed [10:0] flame;
    logic signed [7:0] space;
  } heater_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [7:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = OP_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  heater_req_t heater_reqs[$];
  result_t     due_cmds[$];
  heater_req_t cur_req;
  int          burst_left = 0;
  int          gap_left = 0;
  int          err_count = 0;
  int          clk_count = 0;

  // sequencer shadow: phase, stop flag, phase timer
  logic [2:0]         seq_phase = PH_STANDBY;
  logic               stop_latched = 1'b0;
  logic [TIMER_W-1:0] phase_ms = '0;

  // register shadow
  logic signed [7:0] set_temp = TARGET_TEMP_RST;
  logic [7:0]        spd_low = SPEED_LOW_RST;
  logic [7:0]        spd_mid = SPEED_MID_RST;
  logic [7:0]        spd_high = SPEED_HIGH_RST;
  logic [7:0]        spd_max = SPEED_MAX_RST;

  heater_launch_sequencer_top #(
    .TIMER_BITS(TIMER_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void enter_phase(logic [2:0] p);
    seq_phase = p;
    phase_ms = '0;
  endfunction

  // next state and command pulses for one accepted request
  function automatic result_t advance_sequencer(heater_req_t r);
    result_t o;
    logic    hot;
    o = '0;
    hot = 1'b0;
    case (r.op)
      OP_START: begin
        stop_latched = 1'b0;
        if (seq_phase == PH_STANDBY) enter_phase(PH_COOLING);
      end
      OP_STOP: begin
        stop_latched = 1'b1;
        enter_phase(PH_STANDBY);
      end
      OP_TICK: begin
        if (phase_ms != '1) phase_ms = phase_ms + 1'b1;
        case (seq_phase)
          PH_STANDBY: begin
            if (r.auto_mode && !stop_latched) begin
              if (r.flame == 0) begin
                hot = (phase_ms > T_NOREAD);
              end else if (r.flame >= FLAME_HOT) begin
                hot = 1'b1;
              end else if (phase_ms > T_PUMPUP) begin
                o.rate_write = 1'b1;
                o.rate_value = spd_high;
              end
              if (hot) begin
                o.speed_write = 1'b1;
                o.speed_value = spd_max;
                if (r.space >= set_temp) enter_phase(PH_THERMO);
              end
            end
          end
          PH_FUEL: begin
            if (phase_ms > T_LIGHT) begin
              o.ignite_off = 1'b1;
              o.rate_write = 1'b1;
              o.rate_value = spd_low;
              enter_phase(PH_WARMUP);
            end
          end
          PH_IGNITION: begin
            if (phase_ms > T_GLOW) begin
              o.pump_start = 1'b1;
              o.rate_write = 1'b1;
              o.rate_value = spd_mid;
              enter_phase(PH_FUEL);
            end
          end
          PH_WARMUP: begin
            if (phase_ms > T_WARM) begin
              o.speed_write = 1'b1;
              o.speed_value = spd_max;
              o.rate_write = 1'b1;
              o.rate_value = spd_low;
              enter_phase(PH_STANDBY);
            end
          end
          PH_COOLING: begin
            o.engine_start = 1'b1;
            o.auto_enable = 1'b1;
            if (phase_ms > T_SPINUP) begin
              o.ignite_on = 1'b1;
              enter_phase(PH_IGNITION);
            end
          end
          PH_THERMO: begin
            // 2-degree hysteresis band below the setpoint
            if (r.auto_mode && !stop_latched) begin
              if (r.space >= set_temp) begin
                if (r.eng != spd_mid) begin
                  o.speed_write = 1'b1;
                  o.speed_value = spd_mid;
                end
              end else if (int'(r.space) <= int'(set_temp) - 2) begin
                if (r.eng != spd_high) begin
                  o.speed_write = 1'b1;
                  o.speed_value = spd_high;
                end
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    o.phase = seq_phase;
    o.halted = stop_latched;
    return o;
  endfunction

  function automatic heater_req_t mk_req(op_t op, logic a, logic [7:0] e,
                                         logic signed [10:0] f, logic signed [7:0] s);
    heater_req_t r;
    r.op = op;
    r.auto_mode = a;
    r.eng = e;
    r.flame = f;
    r.space = s;
    return r;
  endfunction

  function automatic heater_req_t rand_req(op_t op);
    return mk_req(op, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  11'(int'($urandom_range(0, 1151)) - 128), 8'($urandom_range(0, 255)));
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    case (idx)
      REG_TARGET_TEMP: set_temp = val;
      REG_SPEED_LOW:   spd_low = val;
      REG_SPEED_MID:   spd_mid = val;
      REG_SPEED_HIGH:  spd_high = val;
      REG_SPEED_MAX:   spd_max = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [7:0] t, logic [7:0] lo, logic [7:0] mid,
                           logic [7:0] hi, logic [7:0] mx);
    write_reg(REG_TARGET_TEMP, t);
    write_reg(REG_SPEED_LOW, lo);
    write_reg(REG_SPEED_MID, mid);
    write_reg(REG_SPEED_HIGH, hi);
    write_reg(REG_SPEED_MAX, mx);
  endtask

  task automatic write_random();
    write_all(8'(int'($urandom_range(0, 180)) - 60), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  // block until every request is taken and every result checked
  task automatic wait_idle();
    do @(negedge clk);
    while (heater_reqs.size() != 0 || s_tvalid || due_cmds.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // random ticks, an occasional ignored request, and starts if start_ok is set
  task automatic push_ticks(int n, bit start_ok);
    for (int i = 0; i < n; i++) begin
      heater_reqs.push_back(rand_req(OP_TICK));
      if ($urandom_range(0, 399) == 0) heater_reqs.push_back(rand_req(OP_NONE));
      if (start_ok && $urandom_range(0, 399) == 0) heater_reqs.push_back(rand_req(OP_START));
    end
  endtask

  // thermostat ticks with space near the setpoint and speed at the set values
  task automatic push_thermo_mix(int n);
    heater_req_t r;
    int          s;
    for (int i = 0; i < n; i++) begin
      r = rand_req(OP_TICK);
      r.auto_mode = ($urandom_range(0, 7) != 0);
      if ($urandom_range(0, 3) != 0) begin
        s = int'(set_temp) + int'($urandom_range(0, 6)) - 3;
        if (s > 127) s = 127;
        if (s < -128) s = -128;
        r.space = 8'(s);
      end
      case ($urandom_range(0, 2))
        0: r.eng = spd_mid;
        1: r.eng = spd_high;
        default: ;
      endcase
      heater_reqs.push_back(r);
      if ($urandom_range(0, 29) == 0) heater_reqs.push_back(rand_req(OP_NONE));
      if ($urandom_range(0, 29) == 0) heater_reqs.push_back(rand_req(OP_START));
    end
  endtask

  // loose mix of all request kinds, with short runs of ticks after a start
  task automatic push_random_mix(int n);
    int k;
    int i;
    i = 0;
    while (i < n) begin
      k = $urandom_range(0, 99);
      if (k < 10) begin
        heater_reqs.push_back(rand_req(OP_START));
        push_ticks($urandom_range(1, 40), 1'b0);
        i += 20;
      end else if (k < 18) begin
        heater_reqs.push_back(rand_req(OP_STOP));
        i++;
      end else if (k < 24) begin
        heater_reqs.push_back(rand_req(OP_NONE));
      end else begin
        heater_reqs.push_back(rand_req(OP_TICK));
        i++;
      end
    end
  endtask

  // standby checks from reset, ending in the thermostat phase
  task automatic push_directed_standby();
    // standby: automatic mode off, no reading, negative and sub-threshold readings
    heater_reqs.push_back(mk_req(OP_TICK, 1'b0, 8'd0, 11'sd50, 8'sd30));
    heater_reqs.push_back(mk_req(OP_TICK, 1'b1, 8'd255, 11'sd0, 8'sd0));
    heater_reqs.push_back(mk_req(OP_TICK, 1'b1, 8'd7, 11'h780, 8'sd127));
    heater_reqs.push_back(mk_req(OP_TICK, 1'b1, 8'd0, 11'sd44, 8'h80));
    // flame at threshold with cold space, then full scale at setpoint
    heater_reqs.push_back(mk_req(OP_TICK, 1'b1, 8'd0, FLAME_HOT, 8'(set_temp - 1)));
    heater_reqs.push_back(mk_req(OP_TICK, 1'b1, 8'd0, 11'sd1023, set_temp));
    // thermostat: speed right, warm, in band, cold at high, cold, then auto off
    heater_reqs.push_back(mk_req(OP_TICK, 1'b1, spd_mid, 11'sd0, set_temp));
    heater_reqs.push_back(mk_req(OP_TICK, 1'b1, 8'd0, 11'sd0, 8'sd127));
    heater_reqs.push_back(mk_req(OP_TICK, 1'b1, 8'd0, 11'sd0, 8'(set_temp - 1)));
    heater_reqs.push_back(mk_req(OP_TICK, 1'b1, spd_high, 11'sd0, 8'(set_temp - 2)));
    heater_reqs.push_back(mk_req(OP_TICK, 1'b1, 8'd255, 11'sd0, 8'h80));
    heater_reqs.push_back(mk_req(OP_TICK, 1'b0, 8'd255, 11'sd0, 8'h80));
  endtask

  // command handling from the thermostat phase, ending halted in standby
  task automatic push_directed_cmds();
    // unused op code, start outside standby, then stop
    heater_reqs.push_back(mk_req(OP_NONE, 1'b1, 8'd255, 11'sd1023, 8'sd127));
    heater_reqs.push_back(rand_req(OP_START));
    heater_reqs.push_back(rand_req(OP_STOP));
    // halted standby ignores a hot reading
    heater_reqs.push_back(mk_req(OP_TICK, 1'b1, 8'd0, 11'sd100, 8'sd127));
    heater_reqs.push_back(mk_req(OP_NONE, 1'b0, 8'd0, 11'sd0, 8'sd0));
    // start into spin-up, start again while spinning, stop
    heater_reqs.push_back(rand_req(OP_START));
    heater_reqs.push_back(rand_req(OP_TICK));
    heater_reqs.push_back(rand_req(OP_START));
    heater_reqs.push_back(rand_req(OP_TICK));
    heater_reqs.push_back(rand_req(OP_STOP));
  endtask

  // stimulus sequence
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    push_directed_standby();
    wait_idle();

    // thermostat: low setpoint with extreme speeds, then the opposite extremes
    write_all(8'hC4, 8'd0, 8'd255, 8'd128, 8'd255);
    push_thermo_mix(150);
    wait_idle();

    write_all(8'd120, 8'd255, 8'd0, 8'd255, 8'd0);
    push_thermo_mix(150);
    wait_idle();

    write_random();
    push_thermo_mix(150);
    wait_idle();

    push_directed_cmds();
    wait_idle();

    for (int p = 0; p < 3; p++) begin
      write_random();
      push_random_mix(260);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // request driver: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) due_cmds.push_back(advance_sequencer(cur_req));
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (heater_reqs.size() != 0) begin
          cur_req = heater_reqs.pop_front();
          s_tdata <= {4'b0, cur_req.space, cur_req.flame, cur_req.eng, cur_req.auto_mode};
          s_tuser <= cur_req.op;
          s_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic cmp_field(string nm, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", nm, want, got);
      err_count++;
    end
  endtask

  // result monitor with a stall pattern that changes with bits 9:8 of clk_count
  always @(posedge clk) begin : result_mon
    result_t got;
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[26:0];
        if (due_cmds.size() == 0) begin
          $error("result with no request outstanding: %h", m_tdata);
          err_count++;
        end else begin
          want = due_cmds.pop_front();
          cmp_field("phase", 8'(want.phase), 8'(got.phase));
          cmp_field("halted", 8'(want.halted), 8'(got.halted));
          cmp_field("engine_start", 8'(want.engine_start), 8'(got.engine_start));
          cmp_field("auto_enable", 8'(want.auto_enable), 8'(got.auto_enable));
          cmp_field("ignite_on", 8'(want.ignite_on), 8'(got.ignite_on));
          cmp_field("ignite_off", 8'(want.ignite_off), 8'(got.ignite_off));
          cmp_field("pump_start", 8'(want.pump_start), 8'(got.pump_start));
          cmp_field("speed_write", 8'(want.speed_write), 8'(got.speed_write));
          cmp_field("speed_value", want.speed_value, got.speed_value);
          cmp_field("rate_write", 8'(want.rate_write), 8'(got.rate_write));
          cmp_field("rate_value", want.rate_value, got.rate_value);
        end
      end
      case (clk_count[9:8])
        2'd0: m_tready <= 1'b1;
        2'd1: m_tready <= clk_count[0];
        2'd2: m_tready <= (clk_count[1:0] != 2'd3);
        default: m_tready <= ($urandom_range(0, 9) > 2);
      endcase
    end
  end

  // run watchdog
  always @(posedge clk) begin
    clk_count <= clk_count + 1;
    if (clk_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
rtl/hls_pkg.sv
rtl/heater_launch_sequencer_top.sv
dv/heater_launch_sequencer_top_tb.sv
